// ----- rtl/core/f21d_pkg.sv -----
// ----------------------------------------------------------------------------
// f21d_pkg
// Shared widths, defaults, tap coefficients and control types for the
// three-channel decimating trace filter.
// ----------------------------------------------------------------------------
package f21d_pkg;

  // Field widths
  localparam int SMP_W     = 12;
  localparam int ADDR_IN_W = 11;
  localparam int BIN_W     = 10;
  localparam int PHASE_W   = 2;
  localparam int NCH       = 3;

  // Filter shape
  localparam int NTAPS       = 21;
  localparam int HALF_TAPS   = 10;
  localparam int TAP_W       = 5;
  localparam int COEF_W      = 11;
  localparam int ACC_W       = 26;
  localparam int SCALE_SHIFT = 11;
  localparam int OUT_MAX     = 4095;

  // Parameter defaults
  localparam int TRACE_LEN_DEF    = 2048;
  localparam int DECIM_FACTOR_DEF = 3;
  localparam int BIN_DELAY_DEF    = 1;

  // Request codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Control word from the sequencer to the MAC bank
  typedef struct packed {
    logic             clear;
    logic             en;
    logic [TAP_W-1:0] tap;
  } mac_ctl_t;

  // Symmetric 21-tap lowpass, gain 2059
  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      5'd0, 5'd20: c = 11'sd5;
      5'd2, 5'd18: c = 11'sd12;
      5'd3, 5'd17: c = 11'sd22;
      5'd5, 5'd15: c = -11'sd61;
      5'd6, 5'd14: c = -11'sd96;
      5'd8, 5'd12: c = 11'sd256;
      5'd9, 5'd11: c = 11'sd551;
      5'd10:       c = 11'sd681;
      default:     c = 11'sd0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/fir21_decimate3_trace_filter.sv -----
// ----------------------------------------------------------------------------
// fir21_decimate3_trace_filter
// Three-channel circular trace with a decimating symmetric 21-tap FIR readout.
//
//   channel   direction  handshake        payload
//   request   in         start / busy     req_type_i, sample_addr_i,
//                                         sample_ch0_i..2_i, bin_request_i
//   result    out        done_o strobe    bin_index_o, filtered_ch0_o..2_o
//   config    in         cfg_we_i         cfg_wdata_i (phase offset)
//
// A load runs the address reduction, then one RAM write; busy drops once the
// write is done.
// A compute runs the centre reduction, a setup state, 21 reads of the single
// RAM read port, a drain state and a result state; the RAM read port paces
// the reads. MOD_STEPS is 2 at defaults.
// busy is low in the result cycle, so a new word may be taken there.
// rst_ni clears control and the phase register; the trace RAM is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module fir21_decimate3_trace_filter #(
  parameter int TRACE_LEN    = f21d_pkg::TRACE_LEN_DEF,
  parameter int DECIM_FACTOR = f21d_pkg::DECIM_FACTOR_DEF,
  parameter int BIN_DELAY    = f21d_pkg::BIN_DELAY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type_i,
  input  logic [f21d_pkg::ADDR_IN_W-1:0]     sample_addr_i,
  input  logic [f21d_pkg::SMP_W-1:0]         sample_ch0_i,
  input  logic [f21d_pkg::SMP_W-1:0]         sample_ch1_i,
  input  logic [f21d_pkg::SMP_W-1:0]         sample_ch2_i,
  input  logic [f21d_pkg::BIN_W-1:0]         bin_request_i,
  // result
  output logic                               done_o,
  output logic [f21d_pkg::BIN_W-1:0]         bin_index_o,
  output logic [f21d_pkg::SMP_W-1:0]         filtered_ch0_o,
  output logic [f21d_pkg::SMP_W-1:0]         filtered_ch1_o,
  output logic [f21d_pkg::SMP_W-1:0]         filtered_ch2_o,
  // config
  input  logic                               cfg_we_i,
  input  logic [f21d_pkg::PHASE_W-1:0]       cfg_wdata_i
);

  localparam int AW      = $clog2(TRACE_LEN);
  localparam int DW      = f21d_pkg::NCH * f21d_pkg::SMP_W;
  // bias that keeps the centre position non-negative before reduction
  localparam int DLY     = DECIM_FACTOR * BIN_DELAY;
  localparam int OFF     = TRACE_LEN * ((DLY + TRACE_LEN - 1) / TRACE_LEN) - DLY;
  localparam int BIN_MAX = (2 ** f21d_pkg::BIN_W) - 1;
  localparam int PH_MAX  = (2 ** f21d_pkg::PHASE_W) - 1;
  localparam int CTR_MAX = DECIM_FACTOR * BIN_MAX + PH_MAX + OFF;
  localparam int ADR_MAX = (2 ** f21d_pkg::ADDR_IN_W) - 1;
  localparam int VAL_MAX = (CTR_MAX > ADR_MAX) ? CTR_MAX : ADR_MAX;
  localparam int VAL_W   = $clog2(VAL_MAX + 1);
  localparam int STEPS_R = $clog2(VAL_MAX / TRACE_LEN + 1);
  localparam int MOD_STEPS = (STEPS_R > 1) ? STEPS_R : 1;
  localparam int DIV_W   = AW + MOD_STEPS;
  localparam int CMP_W   = (VAL_W > DIV_W) ? VAL_W : DIV_W;
  localparam int DIV_INIT = TRACE_LEN * (2 ** (MOD_STEPS - 1));

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MOD   = 7'b0000010,
    ST_WRITE = 7'b0000100,
    ST_SETUP = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e                              state_q, state_d;
  logic                                req_q, req_d;
  logic [f21d_pkg::BIN_W-1:0]          bin_q, bin_d;
  logic [DW-1:0]                       smp_q, smp_d;
  logic [VAL_W-1:0]                    rem_q, rem_d;
  logic [DIV_W-1:0]                    div_q, div_d;
  logic [AW-1:0]                       rd_addr_q, rd_addr_d;
  logic [f21d_pkg::TAP_W-1:0]          tap_q, tap_d;
  f21d_pkg::mac_ctl_t                  mac_ctl_q, mac_ctl_d;
  logic [f21d_pkg::PHASE_W-1:0]        phase_q;

  logic                                accept;
  logic                                mod_last;
  logic [VAL_W-1:0]                    centre_val;
  logic [AW-1:0]                       centre;
  logic [AW:0]                         wrap_sum;
  logic [CMP_W-1:0]                    rem_ext, div_ext;
  logic                                mem_we, mem_re;
  logic [DW-1:0]                       mem_rdata;
  logic [f21d_pkg::NCH-1:0][f21d_pkg::SMP_W-1:0] result;

  assign accept   = start && !busy;
  assign busy     = !(state_q == ST_IDLE || state_q == ST_OUT);
  assign mod_last = (div_q == DIV_W'(TRACE_LEN));
  assign rem_ext  = CMP_W'(rem_q);
  assign div_ext  = CMP_W'(div_q);
  assign centre   = AW'(rem_q);
  assign wrap_sum = (AW+1)'(centre) + (AW+1)'(TRACE_LEN - f21d_pkg::HALF_TAPS);
  assign centre_val = VAL_W'(bin_request_i) * VAL_W'(DECIM_FACTOR)
                    + VAL_W'(phase_q) + VAL_W'(OFF);

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cfg_we_i) begin
      phase_q <= cfg_wdata_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    bin_d     = bin_q;
    smp_d     = smp_q;
    rem_d     = rem_q;
    div_d     = div_q;
    rd_addr_d = rd_addr_q;
    tap_d     = tap_q;
    mac_ctl_d.clear = (state_q == ST_SETUP);
    mac_ctl_d.en    = (state_q == ST_READ);
    mac_ctl_d.tap   = tap_q;

    case (state_q)
      ST_IDLE, ST_OUT: begin
        state_d = ST_IDLE;
        if (accept) begin
          req_d   = req_type_i;
          bin_d   = bin_request_i;
          smp_d   = {sample_ch2_i, sample_ch1_i, sample_ch0_i};
          rem_d   = (req_type_i == f21d_pkg::REQ_COMPUTE) ? centre_val
                                                          : VAL_W'(sample_addr_i);
          div_d   = DIV_W'(DIV_INIT);
          state_d = ST_MOD;
        end
      end
      // restoring reduction modulo the trace length, one shifted step a cycle
      ST_MOD: begin
        if (rem_ext >= div_ext) begin
          rem_d = VAL_W'(rem_ext - div_ext);
        end
        div_d = div_q >> 1;
        if (mod_last) begin
          state_d = (req_q == f21d_pkg::REQ_COMPUTE) ? ST_SETUP : ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      // first tap sits ten entries below the centre, wrapped
      ST_SETUP: begin
        if (centre >= AW'(f21d_pkg::HALF_TAPS)) begin
          rd_addr_d = centre - AW'(f21d_pkg::HALF_TAPS);
        end else begin
          rd_addr_d = wrap_sum[AW-1:0];
        end
        tap_d   = '0;
        state_d = ST_READ;
      end
      ST_READ: begin
        rd_addr_d = (rd_addr_q == AW'(TRACE_LEN - 1)) ? '0 : rd_addr_q + 1'b1;
        tap_d     = tap_q + 1'b1;
        if (tap_q == f21d_pkg::TAP_W'(f21d_pkg::NTAPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      req_q     <= f21d_pkg::REQ_LOAD;
      tap_q     <= '0;
      mac_ctl_q <= '0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      tap_q     <= tap_d;
      mac_ctl_q <= mac_ctl_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    smp_q     <= smp_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    rd_addr_q <= rd_addr_d;
  end

  assign mem_we = (state_q == ST_WRITE);
  assign mem_re = (state_q == ST_READ);

  f21d_trace_ram #(
    .DEPTH (TRACE_LEN),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (centre),
    .wdata_i (smp_q),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  f21d_mac u_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl_q),
    .rdata_i  (mem_rdata),
    .result_o (result)
  );

  // Result word
  assign done_o         = (state_q == ST_OUT);
  assign bin_index_o    = bin_q;
  assign filtered_ch0_o = result[0];
  assign filtered_ch1_o = result[1];
  assign filtered_ch2_o = result[2];

`ifndef SYNTHESIS
  // a result only follows the last accumulate
  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_DRAIN))
    else $error("result strobe without drain");

  // reduction ends inside the trace
  a_mod_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD && mod_last) |=> (CMP_W'(rem_q) < CMP_W'(TRACE_LEN)))
    else $error("reduced address beyond trace");

  // last tap issued carries the MAC enable into the drain cycle
  a_drain_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (mac_ctl_q.en
      && mac_ctl_q.tap == f21d_pkg::TAP_W'(f21d_pkg::NTAPS - 1)))
    else $error("drain without final tap");

  // an accepted word starts the reduction
  a_accept_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MOD))
    else $error("accepted word did not start");
`endif

endmodule

// ----- rtl/core/f21d_trace_ram.sv -----
// ----------------------------------------------------------------------------
// f21d_trace_ram
// Circular sample trace: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module f21d_trace_ram #(
  parameter int DEPTH = f21d_pkg::TRACE_LEN_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = f21d_pkg::NCH * f21d_pkg::SMP_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/f21d_mac.sv -----
// ----------------------------------------------------------------------------
// f21d_mac
// Per-channel multiply-accumulate over the tap sequence, then scale and clamp.
// ----------------------------------------------------------------------------
module f21d_mac (
  input  logic                                         clk_i,
  input  f21d_pkg::mac_ctl_t                           ctl_i,
  input  logic [f21d_pkg::NCH*f21d_pkg::SMP_W-1:0]     rdata_i,
  output logic [f21d_pkg::NCH-1:0][f21d_pkg::SMP_W-1:0] result_o
);

  localparam int PROD_W = f21d_pkg::SMP_W + f21d_pkg::COEF_W + 1;

  logic signed [f21d_pkg::COEF_W-1:0] coef;
  logic signed [PROD_W-1:0]           prod  [f21d_pkg::NCH];
  logic signed [f21d_pkg::ACC_W-1:0]  acc_q [f21d_pkg::NCH];
  logic signed [f21d_pkg::ACC_W-1:0]  acc_d [f21d_pkg::NCH];
  logic        [f21d_pkg::ACC_W-1:0]  scaled[f21d_pkg::NCH];

  assign coef = f21d_pkg::tap_coef(ctl_i.tap);

  // One product per channel, added to its accumulator
  always_comb begin
    for (int c = 0; c < f21d_pkg::NCH; c++) begin
      prod[c] = $signed({1'b0, rdata_i[c*f21d_pkg::SMP_W +: f21d_pkg::SMP_W]}) * coef;
      if (ctl_i.clear) begin
        acc_d[c] = '0;
      end else if (ctl_i.en) begin
        acc_d[c] = acc_q[c] + f21d_pkg::ACC_W'(prod[c]);
      end else begin
        acc_d[c] = acc_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < f21d_pkg::NCH; c++) begin
      acc_q[c] <= acc_d[c];
    end
  end

  // Scale by 2^-11, clamp to the 12-bit range
  always_comb begin
    for (int c = 0; c < f21d_pkg::NCH; c++) begin
      scaled[c] = $unsigned(acc_q[c] >>> f21d_pkg::SCALE_SHIFT);
      if (acc_q[c][f21d_pkg::ACC_W-1]) begin
        result_o[c] = '0;
      end else if (scaled[c] > f21d_pkg::ACC_W'(f21d_pkg::OUT_MAX)) begin
        result_o[c] = f21d_pkg::SMP_W'(f21d_pkg::OUT_MAX);
      end else begin
        result_o[c] = scaled[c][f21d_pkg::SMP_W-1:0];
      end
    end
  end

endmodule
